[hw/rtl/trs_pkg.sv]
`default_nettype none

package trs_pkg;

    localparam int QUAT_W              = 16;
    localparam int R_W                 = 2 * QUAT_W + 2;
    localparam int QUAT_FRAC_BITS_DEF  = 14;
    localparam int COORD_WIDTH_DEF     = 32;

    typedef logic signed [QUAT_W-1:0]   quat_t;
    typedef logic signed [2*QUAT_W-1:0] qprod_t;
    typedef logic signed [R_W-1:0]      rot_t;

endpackage

`default_nettype wire

[hw/rtl/trs_in_if.sv]
`default_nettype none

interface trs_in_if #(
    parameter int COORD_WIDTH = trs_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] scale_x;
    logic signed [COORD_WIDTH-1:0] scale_y;
    logic signed [COORD_WIDTH-1:0] scale_z;
    trs_pkg::quat_t                quat_x;
    trs_pkg::quat_t                quat_y;
    trs_pkg::quat_t                quat_z;
    trs_pkg::quat_t                quat_s;

    modport source (
        output valid, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
               quat_x, quat_y, quat_z, quat_s,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
               quat_x, quat_y, quat_z, quat_s,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/trs_out_if.sv]
`default_nettype none

interface trs_out_if #(
    parameter int COORD_WIDTH = trs_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] m00;
    logic signed [COORD_WIDTH-1:0] m01;
    logic signed [COORD_WIDTH-1:0] m02;
    logic signed [COORD_WIDTH-1:0] m10;
    logic signed [COORD_WIDTH-1:0] m11;
    logic signed [COORD_WIDTH-1:0] m12;
    logic signed [COORD_WIDTH-1:0] m20;
    logic signed [COORD_WIDTH-1:0] m21;
    logic signed [COORD_WIDTH-1:0] m22;
    logic signed [COORD_WIDTH-1:0] tx;
    logic signed [COORD_WIDTH-1:0] ty;
    logic signed [COORD_WIDTH-1:0] tz;

    modport source (
        output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, tx, ty, tz,
        input  ready
    );

    modport sink (
        input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, tx, ty, tz,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/trs_matrix_from_quaternion_unit.sv]
// Builds the top three rows of the object matrix T*R*S from a position, a
// per-axis scale and an orientation quaternion (no normalization). A new
// word is taken every cycle unless every stage is full and the output is
// stalled. Two stages form the quaternion products and the rotation terms,
// two stages multiply by the scale as split partial products and add them
// up, and two stages round half away from zero and saturate to Q16.16. Each
// stage holds its own word under back-pressure, so an empty stage lets input
// flow while a finished result waits at the output.
`default_nettype none

module trs_matrix_from_quaternion_unit #(
    parameter int QUAT_FRAC_BITS = trs_pkg::QUAT_FRAC_BITS_DEF,
    parameter int COORD_WIDTH    = trs_pkg::COORD_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    trs_in_if.sink   in_ch,
    trs_out_if.source out_ch
);
    import trs_pkg::*;

    localparam int PW = R_W + COORD_WIDTH;

    quat_t                         quat [4];
    logic signed [COORD_WIDTH-1:0] pos [3];
    logic signed [COORD_WIDTH-1:0] scale [3];

    logic                          rg_valid;
    logic                          rg_ready;
    rot_t                          rg_rot [9];
    logic signed [COORD_WIDTH-1:0] rg_pos [3];
    logic signed [COORD_WIDTH-1:0] rg_scale [3];

    logic                          sm_valid;
    logic                          sm_ready;
    logic signed [PW-1:0]          sm_prod [9];
    logic signed [COORD_WIDTH-1:0] sm_pos [3];

    logic signed [COORD_WIDTH-1:0] rs_elem [9];
    logic signed [COORD_WIDTH-1:0] rs_pos [3];

    assign quat[0]  = in_ch.quat_x;
    assign quat[1]  = in_ch.quat_y;
    assign quat[2]  = in_ch.quat_z;
    assign quat[3]  = in_ch.quat_s;
    assign pos[0]   = in_ch.pos_x;
    assign pos[1]   = in_ch.pos_y;
    assign pos[2]   = in_ch.pos_z;
    assign scale[0] = in_ch.scale_x;
    assign scale[1] = in_ch.scale_y;
    assign scale[2] = in_ch.scale_z;

    trs_rot_gen #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .COORD_WIDTH    (COORD_WIDTH)
    ) u_rot_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .quat      (quat),
        .pos       (pos),
        .scale     (scale),
        .out_valid (rg_valid),
        .out_ready (rg_ready),
        .rot       (rg_rot),
        .pos_fwd   (rg_pos),
        .scale_fwd (rg_scale)
    );

    trs_scale_mul #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_scale_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rg_valid),
        .in_ready  (rg_ready),
        .rot       (rg_rot),
        .pos       (rg_pos),
        .scale     (rg_scale),
        .out_valid (sm_valid),
        .out_ready (sm_ready),
        .prod      (sm_prod),
        .pos_fwd   (sm_pos)
    );

    trs_round_sat #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .COORD_WIDTH    (COORD_WIDTH)
    ) u_round_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sm_valid),
        .in_ready  (sm_ready),
        .prod      (sm_prod),
        .pos       (sm_pos),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .elem      (rs_elem),
        .pos_fwd   (rs_pos)
    );

    assign out_ch.m00 = rs_elem[0];
    assign out_ch.m01 = rs_elem[1];
    assign out_ch.m02 = rs_elem[2];
    assign out_ch.m10 = rs_elem[3];
    assign out_ch.m11 = rs_elem[4];
    assign out_ch.m12 = rs_elem[5];
    assign out_ch.m20 = rs_elem[6];
    assign out_ch.m21 = rs_elem[7];
    assign out_ch.m22 = rs_elem[8];
    assign out_ch.tx  = rs_pos[0];
    assign out_ch.ty  = rs_pos[1];
    assign out_ch.tz  = rs_pos[2];

    // input only blocks when every stage is full and the output is stalled
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_ch.valid && !out_ch.ready && rg_valid && sm_valid))
        else $error("input stalled with room in the pipeline");

    // rotation terms hold while the multiplier stage is blocked
    a_rot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rg_valid && !rg_ready) |=> (rg_valid && $stable(rg_rot[0])
            && $stable(rg_rot[4]) && $stable(rg_pos[0])))
        else $error("rotation stage changed while stalled");

    // recombined products hold while the rounding stage is blocked
    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (sm_valid && !sm_ready) |=> (sm_valid && $stable(sm_prod[0])
            && $stable(sm_prod[8]) && $stable(sm_pos[2])))
        else $error("product stage changed while stalled");

endmodule

`default_nettype wire

[hw/rtl/trs_rot_gen.sv]
`default_nettype none

module trs_rot_gen #(
    parameter int QUAT_FRAC_BITS = trs_pkg::QUAT_FRAC_BITS_DEF,
    parameter int COORD_WIDTH    = trs_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  trs_pkg::quat_t                quat [4],
    input  logic signed [COORD_WIDTH-1:0] pos [3],
    input  logic signed [COORD_WIDTH-1:0] scale [3],
    output logic                          out_valid,
    input  logic                          out_ready,
    output trs_pkg::rot_t                 rot [9],
    output logic signed [COORD_WIDTH-1:0] pos_fwd [3],
    output logic signed [COORD_WIDTH-1:0] scale_fwd [3]
);
    import trs_pkg::*;

    localparam rot_t ROT_ONE = rot_t'(1) <<< (2 * QUAT_FRAC_BITS);

    function automatic rot_t twice(qprod_t v);
        return rot_t'(v) <<< 1;
    endfunction

    logic   prod_valid_reg;
    logic   rot_valid_reg;
    logic   prod_adv;
    logic   rot_adv;

    qprod_t xx_next, yy_next, zz_next, xy_next, xz_next, yz_next;
    qprod_t xs_next, ys_next, zs_next;
    qprod_t xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    qprod_t xs_reg, ys_reg, zs_reg;

    rot_t   rot_next [9];
    rot_t   rot_reg  [9];

    logic signed [COORD_WIDTH-1:0] pos_a_reg   [3];
    logic signed [COORD_WIDTH-1:0] scale_a_reg [3];
    logic signed [COORD_WIDTH-1:0] pos_b_reg   [3];
    logic signed [COORD_WIDTH-1:0] scale_b_reg [3];

    assign rot_adv  = !rot_valid_reg || out_ready;
    assign prod_adv = !prod_valid_reg || rot_adv;
    assign in_ready = prod_adv;

    // stage a: quaternion products
    always_comb
    begin
        xx_next = qprod_t'(quat[0]) * qprod_t'(quat[0]);
        yy_next = qprod_t'(quat[1]) * qprod_t'(quat[1]);
        zz_next = qprod_t'(quat[2]) * qprod_t'(quat[2]);
        xy_next = qprod_t'(quat[0]) * qprod_t'(quat[1]);
        xz_next = qprod_t'(quat[0]) * qprod_t'(quat[2]);
        yz_next = qprod_t'(quat[1]) * qprod_t'(quat[2]);
        xs_next = qprod_t'(quat[0]) * qprod_t'(quat[3]);
        ys_next = qprod_t'(quat[1]) * qprod_t'(quat[3]);
        zs_next = qprod_t'(quat[2]) * qprod_t'(quat[3]);
    end

    // stage b: rotation elements
    always_comb
    begin
        rot_next[0] = ROT_ONE - twice(yy_reg) - twice(zz_reg);
        rot_next[1] = twice(xy_reg) + twice(zs_reg);
        rot_next[2] = twice(xz_reg) - twice(ys_reg);
        rot_next[3] = twice(xy_reg) - twice(zs_reg);
        rot_next[4] = ROT_ONE - twice(xx_reg) - twice(zz_reg);
        rot_next[5] = twice(yz_reg) + twice(xs_reg);
        rot_next[6] = twice(xz_reg) + twice(ys_reg);
        rot_next[7] = twice(yz_reg) - twice(xs_reg);
        rot_next[8] = ROT_ONE - twice(xx_reg) - twice(yy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            rot_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_adv)
            begin
                prod_valid_reg <= in_valid;
            end
            if (rot_adv)
            begin
                rot_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_adv && in_valid)
        begin
            xx_reg      <= xx_next;
            yy_reg      <= yy_next;
            zz_reg      <= zz_next;
            xy_reg      <= xy_next;
            xz_reg      <= xz_next;
            yz_reg      <= yz_next;
            xs_reg      <= xs_next;
            ys_reg      <= ys_next;
            zs_reg      <= zs_next;
            pos_a_reg   <= pos;
            scale_a_reg <= scale;
        end
        if (rot_adv && prod_valid_reg)
        begin
            rot_reg     <= rot_next;
            pos_b_reg   <= pos_a_reg;
            scale_b_reg <= scale_a_reg;
        end
    end

    assign out_valid = rot_valid_reg;
    assign rot       = rot_reg;
    assign pos_fwd   = pos_b_reg;
    assign scale_fwd = scale_b_reg;

endmodule

`default_nettype wire

[hw/rtl/trs_scale_mul.sv]
`default_nettype none

module trs_scale_mul #(
    parameter int COORD_WIDTH = trs_pkg::COORD_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  trs_pkg::rot_t                           rot [9],
    input  logic signed [COORD_WIDTH-1:0]           pos [3],
    input  logic signed [COORD_WIDTH-1:0]           scale [3],
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [trs_pkg::R_W+COORD_WIDTH-1:0] prod [9],
    output logic signed [COORD_WIDTH-1:0]           pos_fwd [3]
);
    import trs_pkg::*;

    localparam int LO_W = COORD_WIDTH / 2;
    localparam int HI_W = COORD_WIDTH - LO_W;
    localparam int PL_W = R_W + LO_W + 1;
    localparam int PH_W = R_W + HI_W;
    localparam int PW   = R_W + COORD_WIDTH;

    logic                   part_valid_reg;
    logic                   sum_valid_reg;
    logic                   part_adv;
    logic                   sum_adv;

    logic signed [PL_W-1:0] pl_next [9];
    logic signed [PH_W-1:0] ph_next [9];
    logic signed [PL_W-1:0] pl_reg  [9];
    logic signed [PH_W-1:0] ph_reg  [9];
    logic signed [PW-1:0]   sum_next [9];
    logic signed [PW-1:0]   sum_reg  [9];

    logic signed [COORD_WIDTH-1:0] pos_a_reg [3];
    logic signed [COORD_WIDTH-1:0] pos_b_reg [3];

    assign sum_adv  = !sum_valid_reg || out_ready;
    assign part_adv = !part_valid_reg || sum_adv;
    assign in_ready = part_adv;

    // stage c: split scale into low unsigned and high signed halves
    always_comb
    begin
        for (int row = 0; row < 3; row++)
        begin
            for (int col = 0; col < 3; col++)
            begin
                pl_next[row*3+col] = PL_W'(rot[row*3+col])
                    * PL_W'($signed({1'b0, scale[col][LO_W-1:0]}));
                ph_next[row*3+col] = PH_W'(rot[row*3+col])
                    * PH_W'($signed(scale[col][COORD_WIDTH-1:LO_W]));
            end
        end
    end

    // stage d: recombine partial products
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            sum_next[i] = (PW'(ph_reg[i]) <<< LO_W) + PW'(pl_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (part_adv)
            begin
                part_valid_reg <= in_valid;
            end
            if (sum_adv)
            begin
                sum_valid_reg <= part_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (part_adv && in_valid)
        begin
            pl_reg    <= pl_next;
            ph_reg    <= ph_next;
            pos_a_reg <= pos;
        end
        if (sum_adv && part_valid_reg)
        begin
            sum_reg   <= sum_next;
            pos_b_reg <= pos_a_reg;
        end
    end

    assign out_valid = sum_valid_reg;
    assign prod      = sum_reg;
    assign pos_fwd   = pos_b_reg;

endmodule

`default_nettype wire

[hw/rtl/trs_round_sat.sv]
`default_nettype none

module trs_round_sat #(
    parameter int QUAT_FRAC_BITS = trs_pkg::QUAT_FRAC_BITS_DEF,
    parameter int COORD_WIDTH    = trs_pkg::COORD_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [trs_pkg::R_W+COORD_WIDTH-1:0] prod [9],
    input  logic signed [COORD_WIDTH-1:0]           pos [3],
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [COORD_WIDTH-1:0]           elem [9],
    output logic signed [COORD_WIDTH-1:0]           pos_fwd [3]
);
    import trs_pkg::*;

    localparam int PW = R_W + COORD_WIDTH;
    localparam int SH = 2 * QUAT_FRAC_BITS;

    localparam logic signed [PW-1:0] HALF    = PW'(1) <<< (SH - 1);
    localparam logic signed [PW-1:0] HALF_DN = HALF - PW'(1);
    localparam logic signed [PW-1:0] SAT_MAX =
        {{(PW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_MIN =
        {{(PW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    logic                          rnd_valid_reg;
    logic                          res_valid_reg;
    logic                          rnd_adv;
    logic                          res_adv;

    logic signed [PW-1:0]          rnd_next [9];
    logic signed [PW-1:0]          rnd_reg  [9];
    logic signed [PW-1:0]          shifted  [9];
    logic signed [COORD_WIDTH-1:0] res_next [9];
    logic signed [COORD_WIDTH-1:0] res_reg  [9];

    logic signed [COORD_WIDTH-1:0] pos_a_reg [3];
    logic signed [COORD_WIDTH-1:0] pos_b_reg [3];

    assign res_adv  = !res_valid_reg || out_ready;
    assign rnd_adv  = !rnd_valid_reg || res_adv;
    assign in_ready = rnd_adv;

    // stage e: round half away from zero
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            rnd_next[i] = prod[i] + (prod[i][PW-1] ? HALF_DN : HALF);
        end
    end

    // stage f: drop fraction bits and clamp
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            shifted[i] = rnd_reg[i] >>> SH;
            if (shifted[i] > SAT_MAX)
            begin
                res_next[i] = SAT_MAX[COORD_WIDTH-1:0];
            end
            else if (shifted[i] < SAT_MIN)
            begin
                res_next[i] = SAT_MIN[COORD_WIDTH-1:0];
            end
            else
            begin
                res_next[i] = shifted[i][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rnd_adv)
            begin
                rnd_valid_reg <= in_valid;
            end
            if (res_adv)
            begin
                res_valid_reg <= rnd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rnd_adv && in_valid)
        begin
            rnd_reg   <= rnd_next;
            pos_a_reg <= pos;
        end
        if (res_adv && rnd_valid_reg)
        begin
            res_reg   <= res_next;
            pos_b_reg <= pos_a_reg;
        end
    end

    assign out_valid = res_valid_reg;
    assign elem      = res_reg;
    assign pos_fwd   = pos_b_reg;

endmodule

`default_nettype wire

[dv/trs_matrix_checker.sv]
`timescale 1ns / 1ps

module trs_matrix_checker (
    input  logic clk,
    input  logic rst_n,
    trs_in_if    in_mon,
    trs_out_if   out_mon,
    output int   mismatches,
    output int   pending,
    output int   checked
);

    import trs_pkg::*;

    localparam int FRAC = QUAT_FRAC_BITS_DEF;
    localparam int CW   = COORD_WIDTH_DEF;

    typedef logic [CW-1:0]         coord_t;
    typedef logic [11:0][CW-1:0]   matrix_t;

    matrix_t pending_matrices [$];
    matrix_t got;
    matrix_t want;
    int      err_count;
    int      seen;
    string   elem_name [12] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                "m20", "m21", "m22", "tx", "ty", "tz"};

    // rotation term times a Q16.16 scale, rounded half away from zero, clamped
    function automatic coord_t scaled_term(input logic signed [63:0] rot, input coord_t scale);
        logic [127:0] rot_mag;
        logic [127:0] scale_mag;
        logic [127:0] mag;
        logic [127:0] lim;
        logic         neg;
        rot_mag   = {64'd0, (rot < 0) ? -rot : rot};
        scale_mag = {{(128-CW){1'b0}}, scale[CW-1] ? -scale : scale};
        neg       = rot[63] ^ scale[CW-1];
        mag       = (rot_mag * scale_mag + (128'd1 << (2*FRAC-1))) >> (2*FRAC);
        lim       = neg ? (128'd1 << (CW-1)) : (128'd1 << (CW-1)) - 128'd1;
        if (mag > lim)
        begin
            mag = lim;
        end
        return neg ? -mag[CW-1:0] : mag[CW-1:0];
    endfunction

    function automatic matrix_t trs_matrix_of(input quat_t qx, qy, qz, qs,
                                              input coord_t sx, sy, sz, px, py, pz);
        longint  x, y, z, s, one;
        longint  rot [9];
        coord_t  scl [3];
        matrix_t m;
        x   = qx;
        y   = qy;
        z   = qz;
        s   = qs;
        one = longint'(1) << (2*FRAC);
        rot[0] = one - 2*y*y - 2*z*z;
        rot[1] = 2*x*y + 2*z*s;
        rot[2] = 2*x*z - 2*y*s;
        rot[3] = 2*x*y - 2*z*s;
        rot[4] = one - 2*x*x - 2*z*z;
        rot[5] = 2*y*z + 2*x*s;
        rot[6] = 2*x*z + 2*y*s;
        rot[7] = 2*y*z - 2*x*s;
        rot[8] = one - 2*x*x - 2*y*y;
        scl = '{sx, sy, sz};
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m[i*3+j] = scaled_term(rot[i*3+j], scl[j]);
            end
        end
        m[9]  = px;
        m[10] = py;
        m[11] = pz;
        return m;
    endfunction

    initial
    begin
        err_count = 0;
        seen      = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_mon.valid && in_mon.ready)
            begin
                pending_matrices.push_back(trs_matrix_of(
                    in_mon.quat_x, in_mon.quat_y, in_mon.quat_z, in_mon.quat_s,
                    in_mon.scale_x, in_mon.scale_y, in_mon.scale_z,
                    in_mon.pos_x, in_mon.pos_y, in_mon.pos_z));
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got = {out_mon.tz, out_mon.ty, out_mon.tx,
                       out_mon.m22, out_mon.m21, out_mon.m20,
                       out_mon.m12, out_mon.m11, out_mon.m10,
                       out_mon.m02, out_mon.m01, out_mon.m00};
                if (pending_matrices.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("unexpected output word at %0t: %h", $realtime, got);
                    end
                end
                else
                begin
                    want = pending_matrices.pop_front();
                    seen++;
                    for (int k = 0; k < 12; k++)
                    begin
                        if (got[k] !== want[k])
                        begin
                            err_count++;
                            if (err_count <= 10)
                            begin
                                $display("mismatch on %s of matrix %0d: expected %h got %h",
                                         elem_name[k], seen, want[k], got[k]);
                            end
                        end
                    end
                end
            end
            mismatches <= err_count;
            pending    <= pending_matrices.size();
            checked    <= seen;
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int SQUEEZE_CYCLES = 300;
    localparam int SEGMENTS       = 17;
    localparam int SEG_LEN        = 40;

    typedef struct {
        logic [31:0] px, py, pz;
        logic [31:0] sx, sy, sz;
        logic [15:0] qx, qy, qz, qs;
    } xform_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   checked;
    int   sent;
    int   directed;
    int   input_stalls;
    bit   calm;
    bit   squeeze_req;
    bit   squeeze_done;

    trs_in_if  in_ch ();
    trs_out_if out_ch ();

    trs_matrix_from_quaternion_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    trs_matrix_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && !in_ch.ready)
        begin
            input_stalls++;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'h0000_0001;
            4:       return 32'hffff_ffff;
            5:       return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_quat();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'h4000;
            4:       return 16'hc000;
            5:       return 16'h0001;
            6:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic xform_t make_xform(input logic [31:0] px, py, pz, sx, sy, sz,
                                          input logic [15:0] qx, qy, qz, qs);
        xform_t w;
        w.px = px;
        w.py = py;
        w.pz = pz;
        w.sx = sx;
        w.sy = sy;
        w.sz = sz;
        w.qx = qx;
        w.qy = qy;
        w.qz = qz;
        w.qs = qs;
        return w;
    endfunction

    function automatic xform_t rand_xform();
        xform_t w;
        int     kind;
        int     a, b, c, s;
        real    rem;
        kind = $urandom_range(0, 9);
        w.px = $urandom;
        w.py = $urandom;
        w.pz = $urandom;
        w.sx = $urandom;
        w.sy = $urandom;
        w.sz = $urandom;
        w.qx = 16'($urandom);
        w.qy = 16'($urandom);
        w.qz = 16'($urandom);
        w.qs = 16'($urandom);
        if (kind >= 2 && kind <= 7)
        begin
            // close to a unit quaternion
            a   = int'($urandom_range(0, 18000)) - 9000;
            b   = int'($urandom_range(0, 18000)) - 9000;
            c   = int'($urandom_range(0, 18000)) - 9000;
            rem = 268435456.0 - real'(a) * a - real'(b) * b - real'(c) * c;
            s   = $rtoi($sqrt(rem));
            if ($urandom_range(0, 1))
            begin
                s = -s;
            end
            w.qx = 16'(a);
            w.qy = 16'(b);
            w.qz = 16'(c);
            w.qs = 16'(s);
            if (kind <= 5)
            begin
                w.px = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
                w.py = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
                w.pz = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
                w.sx = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                w.sy = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                w.sz = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            end
        end
        else if (kind >= 8)
        begin
            w.px = pick_coord();
            w.py = pick_coord();
            w.pz = pick_coord();
            w.sx = pick_coord();
            w.sy = pick_coord();
            w.sz = pick_coord();
            w.qx = pick_quat();
            w.qy = pick_quat();
            w.qz = pick_quat();
            w.qs = pick_quat();
        end
        return w;
    endfunction

    // entered and left at a falling edge
    task automatic send(input xform_t w);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.pos_x   <= w.px;
        in_ch.pos_y   <= w.py;
        in_ch.pos_z   <= w.pz;
        in_ch.scale_x <= w.sx;
        in_ch.scale_y <= w.sy;
        in_ch.scale_z <= w.sz;
        in_ch.quat_x  <= w.qx;
        in_ch.quat_y  <= w.qy;
        in_ch.quat_z  <= w.qz;
        in_ch.quat_s  <= w.qs;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        sent++;
        @(negedge clk);
    endtask

    // output side
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                hold_left    = SQUEEZE_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (calm)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    out_ch.ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout: results still outstanding");
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        sent          = 0;
        input_stalls  = 0;
        calm          = 1'b0;
        squeeze_req   = 1'b0;
        squeeze_done  = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.pos_x   = '0;
        in_ch.pos_y   = '0;
        in_ch.pos_z   = '0;
        in_ch.scale_x = '0;
        in_ch.scale_y = '0;
        in_ch.scale_z = '0;
        in_ch.quat_x  = '0;
        in_ch.quat_y  = '0;
        in_ch.quat_z  = '0;
        in_ch.quat_s  = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity and no rotation
        send(make_xform(32'h0001_0000, 32'hfffe_0000, 32'h0000_8000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                        16'h0000, 16'h0000, 16'h0000, 16'h4000));
        send(make_xform(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send(make_xform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        16'h0000, 16'h0000, 16'h0000, 16'h0000));
        // large non-unit quaternions saturate both ways
        send(make_xform(32'h0000_0000, 32'hffff_ffff, 32'h0000_0001,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send(make_xform(32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send(make_xform(32'hffff_0000, 32'h0000_ffff, 32'h5555_5555,
                        32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        send(make_xform(32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0000,
                        32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                        16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
        // exact half-way products, both signs
        send(make_xform(32'h0, 32'h0, 32'h0,
                        32'h0400_0000, 32'h0400_0000, 32'h0400_0000,
                        16'h0001, 16'h0001, 16'h0000, 16'h0000));
        send(make_xform(32'h0, 32'h0, 32'h0,
                        32'hfc00_0000, 32'hfc00_0000, 32'hfc00_0000,
                        16'h0001, 16'h0001, 16'h0000, 16'h0000));
        send(make_xform(32'h0, 32'h0, 32'h0,
                        32'h0400_0000, 32'h0400_0000, 32'h0400_0000,
                        16'h0001, 16'hffff, 16'h0000, 16'h0001));
        send(make_xform(32'h0000_0001, 32'hffff_ffff, 32'h0,
                        32'h0000_0001, 32'hffff_ffff, 32'h0000_0001,
                        16'h0000, 16'h0000, 16'h4000, 16'hc000));
        // zero scale, single-axis extremes
        send(make_xform(32'h7fff_ffff, 32'h8000_0000, 32'h0,
                        32'h0, 32'h0, 32'h0,
                        16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
        send(make_xform(32'h0, 32'h0, 32'h0,
                        32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                        16'h8000, 16'h0000, 16'h0000, 16'h0000));
        send(make_xform(32'h0, 32'h0, 32'h0,
                        32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                        16'h0000, 16'h7fff, 16'h0000, 16'h0000));
        send(make_xform(32'h0, 32'h0, 32'h0,
                        32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                        16'h0000, 16'h0000, 16'h8000, 16'h0000));
        send(make_xform(32'h0, 32'h0, 32'h0,
                        32'hffff_0000, 32'hfffe_0000, 32'hfffd_0000,
                        16'h0000, 16'h0000, 16'h0000, 16'h8000));
        send(make_xform(32'h0, 32'h0, 32'h0,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                        16'h8000, 16'h0000, 16'h0000, 16'h7fff));
        directed = sent;

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            calm = (seg % 5 == 2) || (seg == 3);
            if (seg == 3)
            begin
                squeeze_req = 1'b1;
            end
            repeat (SEG_LEN) send(rand_xform());
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge clk);

        $display("sent %0d transforms (%0d directed), checked %0d matrices, %0d mismatches",
                 sent, directed, checked, mismatches);
        $display("input held back for %0d cycles, including a %0d-cycle output hold-off",
                 input_stalls, SQUEEZE_CYCLES);
        if (mismatches == 0 && checked == sent)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/trs_pkg.sv
hw/rtl/trs_in_if.sv
hw/rtl/trs_out_if.sv
hw/rtl/trs_rot_gen.sv
hw/rtl/trs_scale_mul.sv
hw/rtl/trs_round_sat.sv
hw/rtl/trs_matrix_from_quaternion_unit.sv
dv/trs_matrix_checker.sv
dv/tb.sv
